/* rtl/core/qtm_pkg.sv */
// ============================================================================
// qtm_pkg
// Shared types and constants for the quaternion TRS matrix block.
// ============================================================================
package qtm_pkg;

    localparam int LANES        = 9;    // matrix terms, column major
    localparam int PRODW        = 32;   // width of a 16x16 product
    localparam int DW           = 33;   // squared length / divisor
    localparam int NW           = 35;   // signed numerator of a term
    localparam int SW           = 16;   // scale width
    localparam int PW           = NW + SW;  // numerator times scale
    localparam int NUMW         = 58;   // rounded dividend 2*m*256 + d
    localparam int DVW          = DW + 1;   // divisor 2*d
    localparam int QW           = 24;   // quotient bits, |term| <= 2^23
    localparam int FRONT_STAGES = 4;
    localparam int QDEPTH       = 2;

    localparam logic [DW-1:0] LEN_SQ_MIN     = DW'(3);
    localparam logic [DW-1:0] UNNORM_DIVISOR = DW'(64'd1 << 28);

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic signed [15:0] scale_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] c0_r0;
        logic signed [31:0] c0_r1;
        logic signed [31:0] c0_r2;
        logic signed [31:0] c1_r0;
        logic signed [31:0] c1_r1;
        logic signed [31:0] c1_r2;
        logic signed [31:0] c2_r0;
        logic signed [31:0] c2_r1;
        logic signed [31:0] c2_r2;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
    } out_t;

    typedef struct packed {
        logic [NUMW-1:0] rem;
        logic [QW-1:0]   quo;
        logic            neg;
    } lane_t;

    typedef struct packed {
        lane_t [LANES-1:0] lane;
        logic [DVW-1:0]    dv;
        logic [31:0]       trans_x;
        logic [31:0]       trans_y;
        logic [31:0]       trans_z;
    } work_t;

endpackage

/* rtl/core/qtm_front.sv */
// ============================================================================
// qtm_front
// Takes items in, forms the products, the divisor and the nine rounded
// dividends, and hands each work beat to the queue.
// ============================================================================
module qtm_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  qtm_pkg::in_t   in_item,
    input  logic           advance,
    output logic           out_valid,
    output qtm_pkg::work_t out_work
);
    import qtm_pkg::*;

    logic [FRONT_STAGES-1:0] vld_reg;

    // Stage one: products.
    logic signed [PRODW-1:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [PRODW-1:0] xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    logic signed [SW-1:0]    s1_reg [3];
    logic [31:0]             t1_reg [3];

    // Stage two: divisor and numerators.
    logic [DW-1:0]           d2_reg;
    logic signed [NW-1:0]    n2_reg [LANES];
    logic signed [SW-1:0]    s2_reg [3];
    logic [31:0]             t2_reg [3];

    // Stage three: numerator times scale.
    logic [DW-1:0]           d3_reg;
    logic signed [PW-1:0]    p3_reg [LANES];
    logic [31:0]             t3_reg [3];

    // Stage four: work beat.
    work_t                   w4_reg;

    logic [DW-1:0]           sum_sq;
    logic [DW-1:0]           d_next;
    logic signed [NW-1:0]    dn;
    logic signed [NW-1:0]    n_next [LANES];
    work_t                   w_next;

    always_comb
    begin
        sum_sq = DW'($unsigned(xx_reg)) + DW'($unsigned(yy_reg))
               + DW'($unsigned(zz_reg)) + DW'($unsigned(ww_reg));
        d_next = (sum_sq >= LEN_SQ_MIN) ? sum_sq : UNNORM_DIVISOR;
        dn     = $signed({2'b00, d_next});
        n_next[0] = dn - ((NW'(yy_reg) + NW'(zz_reg)) <<< 1);
        n_next[1] = (NW'(xy_reg) + NW'(wz_reg)) <<< 1;
        n_next[2] = (NW'(xz_reg) - NW'(wy_reg)) <<< 1;
        n_next[3] = (NW'(xy_reg) - NW'(wz_reg)) <<< 1;
        n_next[4] = dn - ((NW'(xx_reg) + NW'(zz_reg)) <<< 1);
        n_next[5] = (NW'(yz_reg) + NW'(wx_reg)) <<< 1;
        n_next[6] = (NW'(xz_reg) + NW'(wy_reg)) <<< 1;
        n_next[7] = (NW'(yz_reg) - NW'(wx_reg)) <<< 1;
        n_next[8] = dn - ((NW'(xx_reg) + NW'(yy_reg)) <<< 1);
    end

    // Rounding to nearest with ties away from zero: floor((2m + d) / 2d).
    always_comb
    begin
        w_next         = '0;
        w_next.dv      = {1'b0, d3_reg} << 1;
        w_next.trans_x = t3_reg[0];
        w_next.trans_y = t3_reg[1];
        w_next.trans_z = t3_reg[2];
        for (int k = 0; k < LANES; k++)
        begin
            logic [PW-1:0] mag;
            mag = p3_reg[k][PW-1] ? $unsigned(-p3_reg[k]) : $unsigned(p3_reg[k]);
            w_next.lane[k].neg = p3_reg[k][PW-1];
            w_next.lane[k].rem = (NUMW'(mag) << 9) + NUMW'(d3_reg);
            w_next.lane[k].quo = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            xx_reg <= in_item.quat_x * in_item.quat_x;
            yy_reg <= in_item.quat_y * in_item.quat_y;
            zz_reg <= in_item.quat_z * in_item.quat_z;
            ww_reg <= in_item.quat_w * in_item.quat_w;
            xy_reg <= in_item.quat_x * in_item.quat_y;
            xz_reg <= in_item.quat_x * in_item.quat_z;
            yz_reg <= in_item.quat_y * in_item.quat_z;
            wx_reg <= in_item.quat_w * in_item.quat_x;
            wy_reg <= in_item.quat_w * in_item.quat_y;
            wz_reg <= in_item.quat_w * in_item.quat_z;
            s1_reg[0] <= in_item.scale_x;
            s1_reg[1] <= in_item.scale_y;
            s1_reg[2] <= in_item.scale_z;
            t1_reg[0] <= in_item.pos_x;
            t1_reg[1] <= in_item.pos_y;
            t1_reg[2] <= in_item.pos_z;

            d2_reg <= d_next;
            n2_reg <= n_next;
            s2_reg <= s1_reg;
            t2_reg <= t1_reg;

            d3_reg <= d2_reg;
            for (int k = 0; k < LANES; k++)
            begin
                p3_reg[k] <= PW'(n2_reg[k]) * PW'(s2_reg[k / 3]);
            end
            t3_reg <= t2_reg;

            w4_reg <= w_next;
        end
    end

    assign out_valid = vld_reg[FRONT_STAGES-1];
    assign out_work  = w4_reg;

endmodule

/* rtl/core/qtm_queue.sv */
// ============================================================================
// qtm_queue
// Two-entry queue of work beats between the front and the divider lanes.
// ============================================================================
module qtm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  qtm_pkg::work_t push_work,
    output logic           full,
    output logic           pop_valid,
    output qtm_pkg::work_t pop_work
);
    import qtm_pkg::*;

    localparam int PTRW = $clog2(QDEPTH);

    work_t              mem_reg [QDEPTH];
    logic [PTRW-1:0]    wr_ptr_reg;
    logic [PTRW-1:0]    rd_ptr_reg;
    logic [PTRW:0]      count_reg;
    logic               pop;

    // The divider lanes never stall, so a waiting beat leaves at once.
    assign pop       = (count_reg != '0);
    assign pop_valid = pop;
    assign pop_work  = mem_reg[rd_ptr_reg];
    assign full      = (count_reg == (PTRW + 1)'(QDEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= PTRW'((32'(wr_ptr_reg) + 1) % QDEPTH);
            end
            if (pop)
            begin
                rd_ptr_reg <= PTRW'((32'(rd_ptr_reg) + 1) % QDEPTH);
            end
            count_reg <= count_reg + (PTRW + 1)'(push) - (PTRW + 1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_work;
        end
    end

endmodule

/* rtl/core/qtm_back.sv */
// ============================================================================
// qtm_back
// Nine restoring divider lanes, one quotient bit per stage, then sign
// and output register.
// ============================================================================
module qtm_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  qtm_pkg::work_t in_work,
    output logic           done,
    output qtm_pkg::out_t  result
);
    import qtm_pkg::*;

    work_t        st_reg  [QW+1];
    work_t        st_next [QW+1];
    logic [QW:0]  vld_reg;
    out_t         res_reg;
    out_t         res_next;
    logic         done_reg;
    logic [31:0]  val [LANES];

    // Stage k settles quotient bit QW-1-k of every lane.
    always_comb
    begin
        st_next[0] = in_work;
        for (int k = 0; k < QW; k++)
        begin
            st_next[k+1] = st_reg[k];
            for (int l = 0; l < LANES; l++)
            begin
                logic [NUMW-1:0] dsh;
                dsh = NUMW'(st_reg[k].dv) << (QW - 1 - k);
                if (st_reg[k].lane[l].rem >= dsh)
                begin
                    st_next[k+1].lane[l].rem             = st_reg[k].lane[l].rem - dsh;
                    st_next[k+1].lane[l].quo[QW - 1 - k] = 1'b1;
                end
            end
        end
    end

    // The quotient stays below 2^24, so negating it into a signed 32-bit value needs no clamp.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            val[l] = st_reg[QW].lane[l].neg ? -(32'(st_reg[QW].lane[l].quo))
                                            : 32'(st_reg[QW].lane[l].quo);
        end
        res_next.c0_r0   = val[0];
        res_next.c0_r1   = val[1];
        res_next.c0_r2   = val[2];
        res_next.c1_r0   = val[3];
        res_next.c1_r1   = val[4];
        res_next.c1_r2   = val[5];
        res_next.c2_r0   = val[6];
        res_next.c2_r1   = val[7];
        res_next.c2_r2   = val[8];
        res_next.trans_x = st_reg[QW].trans_x;
        res_next.trans_y = st_reg[QW].trans_y;
        res_next.trans_z = st_reg[QW].trans_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[QW-1:0], in_valid};
            done_reg <= vld_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= QW; k++)
        begin
            st_reg[k] <= st_next[k];
        end
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* rtl/core/quaternion_trs_matrix.sv */
// ============================================================================
// quaternion_trs_matrix
// Builds the upper three rows of a translate-rotate-scale matrix from a
// quaternion, axis scales and a translation.
// ============================================================================
//
//  channel   handshake          payload
//  -------   ----------------   --------------------------
//  item      start / busy       quaternion, scale, position
//  result    done (one cycle)   nine matrix terms, translation
//
//  One beat is taken per cycle while busy is low. Its result goes through
//  the front stages, the queue, the divider lanes and the output register.
//  The latency is set mostly by the 24-stage divider lanes, one quotient
//  bit a stage, behind the four front stages and the queue.
//  busy rises only if the front-to-back queue fills, which the never
//  stalling divider lanes prevent. Reset empties all pipelines.
//
module quaternion_trs_matrix (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  qtm_pkg::in_t  item,
    output logic          done,
    output qtm_pkg::out_t result
);
    import qtm_pkg::*;

    logic   advance;
    logic   q_full;
    logic   f_valid;
    work_t  f_work;
    logic   b_valid;
    work_t  b_work;

    assign advance = !q_full;
    assign busy    = q_full;

    qtm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_item   (item),
        .advance   (advance),
        .out_valid (f_valid),
        .out_work  (f_work)
    );

    qtm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid && advance),
        .push_work (f_work),
        .full      (q_full),
        .pop_valid (b_valid),
        .pop_work  (b_work)
    );

    qtm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (b_valid),
        .in_work  (b_work),
        .done     (done),
        .result   (result)
    );

`ifndef SYNTHESIS
    localparam int LATENCY = FRONT_STAGES + QW + 3;

    // The queue drains every cycle, so it can never fill.
    assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("front-to-back queue filled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted beat gave no result in time");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result beat out of step with accepted beat");
`endif

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb
// Drives quaternion, scale and translation beats into the TRS matrix block,
// predicts each matrix with exact integer arithmetic and compares results.
// ============================================================================
module tb;
    import qtm_pkg::*;

    localparam int IN_BITS = $bits(in_t);

    typedef struct packed {
        bit          has_diag;
        logic [31:0] diag;
    } typed_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_t  item;
    logic done;
    out_t result;

    quaternion_trs_matrix dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    out_t   matrix_q[$];
    typed_t typed_q[$];
    bit     typed_now;
    logic signed [31:0] typed_diag;
    int     mismatches;
    int     beats_sent;
    int     matrices_seen;
    int     short_quats;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Nearest integer to n*s*256/d, ties away from zero, saturated.
    function automatic logic signed [31:0] scaled_term(longint n, longint s, longint d);
        longint p;
        longint m;
        longint q;
        p = n * s * 256;
        m = (p < 0) ? -p : p;
        q = (2 * m + d) / (2 * d);
        if (p < 0)
            return (q > 64'sh80000000) ? 32'sh80000000 : 32'(-q);
        return (q > 64'sh7FFFFFFF) ? 32'sh7FFFFFFF : 32'(q);
    endfunction

    function automatic out_t trs_matrix(in_t b);
        longint x;
        longint y;
        longint z;
        longint w;
        longint len_sq;
        longint d;
        out_t   r;
        x = b.quat_x;
        y = b.quat_y;
        z = b.quat_z;
        w = b.quat_w;
        len_sq = x * x + y * y + z * z + w * w;
        d = (len_sq >= 3) ? len_sq : (64'sd1 << 28);
        r.c0_r0 = scaled_term(d - 2 * (y * y + z * z), b.scale_x, d);
        r.c0_r1 = scaled_term(2 * (x * y + w * z), b.scale_x, d);
        r.c0_r2 = scaled_term(2 * (x * z - w * y), b.scale_x, d);
        r.c1_r0 = scaled_term(2 * (x * y - w * z), b.scale_y, d);
        r.c1_r1 = scaled_term(d - 2 * (x * x + z * z), b.scale_y, d);
        r.c1_r2 = scaled_term(2 * (y * z + w * x), b.scale_y, d);
        r.c2_r0 = scaled_term(2 * (x * z + w * y), b.scale_z, d);
        r.c2_r1 = scaled_term(2 * (y * z - w * x), b.scale_z, d);
        r.c2_r2 = scaled_term(d - 2 * (x * x + y * y), b.scale_z, d);
        r.trans_x = b.pos_x;
        r.trans_y = b.pos_y;
        r.trans_z = b.pos_z;
        return r;
    endfunction

    function automatic in_t make_beat(logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
                                      logic [15:0] qw, logic [15:0] s, logic [31:0] p);
        in_t b;
        b.quat_x = qx;
        b.quat_y = qy;
        b.quat_z = qz;
        b.quat_w = qw;
        b.scale_x = s;
        b.scale_y = s;
        b.scale_z = s;
        b.pos_x = p;
        b.pos_y = ~p;
        b.pos_z = p ^ 32'h5A5A_A5A5;
        return b;
    endfunction

    function automatic in_t random_beat();
        in_t b;
        int  kind;
        b = in_t'(IN_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom}));
        kind = $urandom_range(0, 9);
        // Half the beats get quaternion components within +-16384.
        if (kind < 5)
        begin
            b.quat_x = 16'($signed($urandom_range(0, 32768)) - 16384);
            b.quat_y = 16'($signed($urandom_range(0, 32768)) - 16384);
            b.quat_z = 16'($signed($urandom_range(0, 32768)) - 16384);
            b.quat_w = 16'($signed($urandom_range(0, 32768)) - 16384);
        end
        else if (kind == 5)
        begin
            // Squared length at or just around the normalization threshold.
            b.quat_x = 16'($signed($urandom_range(0, 2)) - 1);
            b.quat_y = 16'($signed($urandom_range(0, 2)) - 1);
            b.quat_z = 16'($signed($urandom_range(0, 2)) - 1);
            b.quat_w = 16'($signed($urandom_range(0, 4)) - 2);
        end
        if (kind > 7)
        begin
            b.scale_x = 16'($signed($urandom_range(0, 1024)) - 512);
            b.scale_y = 16'($signed($urandom_range(0, 1024)) - 512);
            b.scale_z = 16'($signed($urandom_range(0, 1024)) - 512);
        end
        return b;
    endfunction

    task automatic send_beat(in_t b, bit idle_ok);
        int gap;
        if (idle_ok && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        item  <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        beats_sent++;
        if (longint'(b.quat_x) * b.quat_x + longint'(b.quat_y) * b.quat_y
            + longint'(b.quat_z) * b.quat_z + longint'(b.quat_w) * b.quat_w < 3)
            short_quats++;
        @(negedge clk);
    endtask

    task automatic check_field(string tag, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch on %s: expected %h, got %h", tag, exp_v, act_v);
        end
    endtask

    // Predict at the accepted beat, check at the result strobe.
    always @(posedge clk)
    begin
        out_t   e;
        typed_t t;
        if (rst_n && start && !busy)
        begin
            matrix_q.insert(matrix_q.size(), trs_matrix(item));
            typed_q.insert(typed_q.size(), '{typed_now, typed_diag});
        end
        if (rst_n && done)
        begin
            matrices_seen++;
            if (matrix_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result %h", result);
            end
            else
            begin
                e = matrix_q.pop_front();
                t = typed_q.pop_front();
                if (t.has_diag)
                begin
                    // Hand-typed diagonal, independent of the predictor.
                    check_field("typed c0_r0", t.diag, result.c0_r0);
                    check_field("typed c1_r1", t.diag, result.c1_r1);
                    check_field("typed c2_r2", t.diag, result.c2_r2);
                end
                check_field("c0_r0", e.c0_r0, result.c0_r0);
                check_field("c0_r1", e.c0_r1, result.c0_r1);
                check_field("c0_r2", e.c0_r2, result.c0_r2);
                check_field("c1_r0", e.c1_r0, result.c1_r0);
                check_field("c1_r1", e.c1_r1, result.c1_r1);
                check_field("c1_r2", e.c1_r2, result.c1_r2);
                check_field("c2_r0", e.c2_r0, result.c2_r0);
                check_field("c2_r1", e.c2_r1, result.c2_r1);
                check_field("c2_r2", e.c2_r2, result.c2_r2);
                check_field("trans_x", e.trans_x, result.trans_x);
                check_field("trans_y", e.trans_y, result.trans_y);
                check_field("trans_z", e.trans_z, result.trans_z);
            end
        end
    end

    // Directed rows. Three rows carry an expected diagonal typed in by hand:
    // the identity quaternion and the zero quaternion, all giving a pure
    // scale matrix with diagonal scale*256.
    typedef struct {
        in_t              beat;
        bit               has_diag;
        logic signed [31:0] diag;
    } row_t;

    row_t rows[$];

    initial
    begin
        row_t r;
        int   timeout_wait;
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        typed_now = 1'b0;
        typed_diag = '0;
        mismatches = 0;
        beats_sent = 0;
        matrices_seen = 0;
        short_quats = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        r.has_diag = 1; r.diag = 32'sd256 * 256;
        r.beat = make_beat(16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0100, 32'h0001_0000);
        rows.insert(rows.size(), r);
        r.beat = make_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 32'h8000_0000);
        rows.insert(rows.size(), r);
        r.diag = -32'sd32768 * 256;
        r.beat = make_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 32'h7FFF_FFFF);
        rows.insert(rows.size(), r);
        r.has_diag = 0; r.diag = 0;
        rows.insert(rows.size(), '{make_beat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                             16'h7FFF, 32'hFFFF_FFFF), 0, 0});
        rows.insert(rows.size(), '{make_beat(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                             16'h8000, 32'h0000_0000), 0, 0});
        rows.insert(rows.size(), '{make_beat(16'h8000, 16'h7FFF, 16'h0000, 16'h8000,
                                             16'h7FFF, 32'h1234_5678), 0, 0});
        // Squared lengths of 1, 2 (used unnormalized) and 3, 4 (normalized).
        rows.insert(rows.size(), '{make_beat(16'h0001, 16'h0000, 16'h0000, 16'h0000,
                                             16'h7FFF, 32'h0), 0, 0});
        rows.insert(rows.size(), '{make_beat(16'hFFFF, 16'h0001, 16'h0000, 16'h0000,
                                             16'h8000, 32'h0), 0, 0});
        rows.insert(rows.size(), '{make_beat(16'h0001, 16'hFFFF, 16'h0001, 16'h0000,
                                             16'h7FFF, 32'h0), 0, 0});
        rows.insert(rows.size(), '{make_beat(16'h0001, 16'h0001, 16'h0001, 16'hFFFF,
                                             16'h8000, 32'h0), 0, 0});
        rows.insert(rows.size(), '{make_beat(16'h2D41, 16'h0000, 16'h0000, 16'h2D41,
                                             16'hFF00, 32'hDEAD_BEEF), 0, 0});
        rows.insert(rows.size(), '{make_beat(16'h0000, 16'h4000, 16'h0000, 16'h0000,
                                             16'h0001, 32'h0000_0001), 0, 0});
        rows.insert(rows.size(), '{make_beat(16'h0000, 16'h0000, 16'hC000, 16'h0000,
                                             16'hFFFF, 32'hAAAA_AAAA), 0, 0});

        foreach (rows[i])
        begin
            typed_now  = rows[i].has_diag;
            typed_diag = rows[i].diag;
            send_beat(rows[i].beat, 0);
        end
        typed_now = 1'b0;
        start <= 1'b0;

        for (int i = 0; i < 1200; i++)
        begin
            send_beat(random_beat(), i < 1000);
            if (i == 500)
            begin
                // Drain the pipeline completely once mid-run.
                start <= 1'b0;
                while (matrix_q.size() != 0)
                    @(negedge clk);
            end
        end
        start <= 1'b0;

        timeout_wait = 0;
        while (matrix_q.size() != 0 && timeout_wait < 1000)
        begin
            @(negedge clk);
            timeout_wait++;
        end
        repeat (40) @(negedge clk);

        $display("Sent %0d beats (%0d with a short quaternion), checked %0d matrices.",
                 beats_sent, short_quats, matrices_seen);
        if (mismatches == 0 && matrix_q.size() == 0)
            $display("Simulation PASSED");
        else
        begin
            if (matrix_q.size() != 0)
                $display("%0d results never arrived", matrix_q.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #200000;
        $display("Timeout");
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/core/qtm_pkg.sv
rtl/core/qtm_front.sv
rtl/core/qtm_queue.sv
rtl/core/qtm_back.sv
rtl/core/quaternion_trs_matrix.sv
tb/sv/tb.sv
